>>> src/rdft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdft_pkg
// shared types and constants of the repeated digest flood table
// ----------------------------------------------------------------------------
package rdft_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    // configuration reset values
    localparam logic [15:0] REPEAT_LIMIT_RST = 16'd10;
    localparam logic [15:0] WATCH_TIME_RST   = 16'd600;

    // configuration register indexes
    localparam logic [1:0] CFG_FILTER_ENABLED   = 2'd0;
    localparam logic [1:0] CFG_REPEAT_LIMIT     = 2'd1;
    localparam logic [1:0] CFG_WATCH_TIME       = 2'd2;
    localparam logic [1:0] CFG_IGNORE_OPERATORS = 2'd3;

    // command classes from the front
    localparam logic [1:0] CMD_SKIP  = 2'd0;
    localparam logic [1:0] CMD_COUNT = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic        filter_enabled;
        logic [15:0] repeat_limit;
        logic [15:0] watch_time;
        logic        ignore_operators;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] digest;
        logic [31:0] now_time;
    } cmd_item_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] digest;
        logic [15:0] count;
        logic [31:0] last_seen;
    } entry_t;

    typedef struct packed {
        logic        flood_alarm;
        logic [15:0] hit_count;
        logic [6:0]  evicted_count;
        logic        table_full_drop;
    } result_t;

endpackage

>>> src/rdft_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdft_front
// accepts input items, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module rdft_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  rdft_pkg::cfg_t      cfg,
    input  logic                hold,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_kind,
    input  logic [63:0]         s_digest,
    input  logic [31:0]         s_now_time,
    input  logic                s_sender_local,
    input  logic                s_sender_operator,
    input  logic                s_to_user,
    output logic                q_valid,
    output rdft_pkg::cmd_item_t q_item,
    input  logic                q_pop
);

    rdft_pkg::cmd_item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    rdft_pkg::cmd_item_t cls;
    logic       push;

    // classify the incoming item
    always_comb begin
        cls.digest   = s_digest;
        cls.now_time = s_now_time;
        if (s_kind) begin
            cls.cmd = rdft_pkg::CMD_TICK;
        end else if (cfg.filter_enabled && s_sender_local && s_to_user &&
                     !(cfg.ignore_operators && s_sender_operator)) begin
            cls.cmd = rdft_pkg::CMD_COUNT;
        end else begin
            cls.cmd = rdft_pkg::CMD_SKIP;
        end
    end

    assign s_tready = (fill_reg != 2'd2) && !hold;
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];

    // queue pointers
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        fill_next   = fill_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> src/rdft_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdft_back
// scans the entry memory for lookups, inserts and sweeps, and drives results
// ----------------------------------------------------------------------------
module rdft_back #(
    parameter int TABLE_ENTRIES = rdft_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rdft_pkg::cfg_t      cfg,
    output logic                clearing,
    input  logic                q_valid,
    input  rdft_pkg::cmd_item_t q_item,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output rdft_pkg::result_t   m_result
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IW:0] LAST = (IW + 1)'(TABLE_ENTRIES);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    rdft_pkg::entry_t mem [TABLE_ENTRIES];
    rdft_pkg::entry_t rd_data_reg;

    logic [2:0]    state_reg, state_next;
    logic [IW:0]   ptr_reg, ptr_next;
    logic          rd_v_reg, rd_v_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next;
    logic [15:0]   hit_cnt_reg, hit_cnt_next;
    logic          free_reg, free_next;
    logic [IW-1:0] free_idx_reg, free_idx_next;
    logic [6:0]    evc_reg, evc_next;
    rdft_pkg::result_t res_reg, res_next;
    rdft_pkg::result_t out_reg, out_next;
    logic          out_v_reg, out_v_next;

    logic             we;
    logic [IW-1:0]    waddr;
    rdft_pkg::entry_t wdata;
    logic [IW-1:0]    raddr;
    logic             re;
    logic [15:0]      base_cnt, new_cnt;
    logic             expired;

    assign clearing = (state_reg == ST_CLEAR);
    assign m_tvalid = out_v_reg;
    assign m_result = out_reg;

    // eviction test without wrap
    assign expired = {1'b0, q_item.now_time} >
                     ({1'b0, rd_data_reg.last_seen} + {17'b0, cfg.watch_time});

    always_comb begin
        base_cnt = hit_reg ? hit_cnt_reg : 16'd0;
        new_cnt  = (base_cnt == rdft_pkg::COUNT_MAX) ? base_cnt : base_cnt + 16'd1;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        rd_v_next     = 1'b0;
        rd_idx_next   = rd_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_cnt_next  = hit_cnt_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        evc_next      = evc_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        out_v_next    = out_v_reg && !m_tready;
        q_pop         = 1'b0;
        we            = 1'b0;
        waddr         = rd_idx_reg;
        wdata         = rd_data_reg;
        re            = 1'b0;
        raddr         = ptr_reg[IW-1:0];
        case (state_reg)
            ST_CLEAR: begin
                we          = 1'b1;
                waddr       = ptr_reg[IW-1:0];
                wdata       = '0;
                ptr_next    = ptr_reg + 1'b1;
                if (ptr_reg == LAST - 1'b1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ptr_next  = '0;
                hit_next  = 1'b0;
                free_next = 1'b0;
                evc_next  = '0;
                if (q_valid) begin
                    if (q_item.cmd == rdft_pkg::CMD_SKIP) begin
                        res_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // issue one read per cycle
                if (ptr_reg != LAST) begin
                    re          = 1'b1;
                    rd_v_next   = 1'b1;
                    rd_idx_next = ptr_reg[IW-1:0];
                    ptr_next    = ptr_reg + 1'b1;
                end
                // handle the entry read last cycle
                if (rd_v_reg) begin
                    if (q_item.cmd == rdft_pkg::CMD_TICK) begin
                        if (rd_data_reg.valid && expired) begin
                            we          = 1'b1;
                            wdata.valid = 1'b0;
                            evc_next    = evc_reg + 7'd1;
                        end
                    end else if (rd_data_reg.valid) begin
                        if (!hit_reg && rd_data_reg.digest == q_item.digest) begin
                            hit_next     = 1'b1;
                            hit_idx_next = rd_idx_reg;
                            hit_cnt_next = rd_data_reg.count;
                        end
                    end else if (!free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                end
                if (ptr_reg == LAST && !rd_v_reg) begin
                    if (q_item.cmd == rdft_pkg::CMD_TICK) begin
                        res_next               = '0;
                        res_next.evicted_count = evc_reg;
                        state_next             = ST_DONE;
                    end else begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                res_next = '0;
                if (hit_reg || free_reg) begin
                    we              = 1'b1;
                    waddr           = hit_reg ? hit_idx_reg : free_idx_reg;
                    wdata.valid     = 1'b1;
                    wdata.digest    = q_item.digest;
                    wdata.count     = new_cnt;
                    wdata.last_seen = q_item.now_time;
                    res_next.hit_count   = new_cnt;
                    res_next.flood_alarm = (new_cnt >= cfg.repeat_limit);
                end else begin
                    res_next.table_full_drop = 1'b1;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_v_reg || m_tready) begin
                    out_next   = res_reg;
                    out_v_next = 1'b1;
                    q_pop      = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            ptr_reg   <= '0;
            rd_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            evc_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            rd_v_reg  <= rd_v_next;
            out_v_reg <= out_v_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            evc_reg   <= evc_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        free_idx_reg <= free_idx_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    // entry memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem[raddr];
        end
    end

endmodule

>>> src/repeated_digest_flood_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeated_digest_flood_table_core
// counts repeated message digests in a bounded table and ages entries out
// ----------------------------------------------------------------------------
// Input items arrive on the s_ stream: tuser is the kind (0 message, 1 tick),
// tdata carries digest, time and sender flags. One result item per input
// leaves on the m_ stream. Configuration is a plain write port (cfg_we,
// cfg_index, cfg_data); the user keeps it written only while the block is
// idle, which the block itself does not enforce. A front classifies items
// into a two-entry queue; a back walks the entry memory one entry per cycle
// through its single read port. A counted message goes through scan, update
// and result, a tick through scan and result, a skipped message to result.
// After reset the back clears every memory entry and s_tready stays low until
// that pass ends. A stalled m_ side holds the result in the output register;
// the queue still takes up to two more items.
// ----------------------------------------------------------------------------
module repeated_digest_flood_table_core #(
    parameter int TABLE_ENTRIES = rdft_pkg::TABLE_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // digest[63:0], now_time[95:64], sender_local[96],
                                   // sender_operator[97], to_user[98], zero pad
    input  logic         s_tuser,  // kind[0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata   // flood_alarm[0], hit_count[16:1],
                                   // evicted_count[23:17], table_full_drop[24], zero pad
);

    rdft_pkg::cfg_t      cfg_reg;
    rdft_pkg::cmd_item_t q_item;
    rdft_pkg::result_t   res;
    logic                q_valid, q_pop, clearing;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.filter_enabled   <= 1'b0;
            cfg_reg.repeat_limit     <= rdft_pkg::REPEAT_LIMIT_RST;
            cfg_reg.watch_time       <= rdft_pkg::WATCH_TIME_RST;
            cfg_reg.ignore_operators <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                rdft_pkg::CFG_FILTER_ENABLED:   cfg_reg.filter_enabled   <= cfg_data[0];
                rdft_pkg::CFG_REPEAT_LIMIT:     cfg_reg.repeat_limit     <= cfg_data;
                rdft_pkg::CFG_WATCH_TIME:       cfg_reg.watch_time       <= cfg_data;
                rdft_pkg::CFG_IGNORE_OPERATORS: cfg_reg.ignore_operators <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    rdft_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .hold              (clearing),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_kind            (s_tuser),
        .s_digest          (s_tdata[63:0]),
        .s_now_time        (s_tdata[95:64]),
        .s_sender_local    (s_tdata[96]),
        .s_sender_operator (s_tdata[97]),
        .s_to_user         (s_tdata[98]),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop)
    );

    rdft_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .clearing (clearing),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (res)
    );

    // pack the result
    assign m_tdata = {7'd0, res.table_full_drop, res.evicted_count,
                      res.hit_count, res.flood_alarm};

endmodule
